// ----- rtl/text_console_writer_macros.svh -----
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Clocked assertion wrappers used by the console sequencer RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define TCW_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tcw assertion failed");

// Consequent must hold in the cycle of the antecedent.
`define TCW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcw assertion failed");

`else

`define TCW_ASSERT(label, cond)
`define TCW_ASSERT_IMPL(label, ante, cons)

`endif

`endif

// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, command codes and the bundles passed between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS        = 80;
  localparam int ROWS           = 25;
  localparam int CELLS          = COLUMNS * ROWS;
  localparam int LAST_ROW_START = (ROWS - 1) * COLUMNS;

  localparam int ADDR_W   = 11;
  localparam int CELL_W   = 16;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 4;
  localparam int KIND_W   = 3;
  localparam int FIELD_W  = 8;
  localparam int SCROLL_W = $clog2(ROWS + 1);

  localparam logic [CHAR_W-1:0]  SPACE_CODE = 8'h20;
  localparam logic [COLOR_W-1:0] FG_RESET   = 4'd7;

  localparam logic [KIND_W-1:0] KIND_PUT_CHAR = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NEW_LINE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CR       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PUT_AT   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SCROLL   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd6;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] cursor;
    logic [CELL_W-1:0] data;
  } res_t;

endpackage

// ----- rtl/tcw_screen_mem.sv -----
// ----------------------------------------------------------------------------
// Screen cell memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_screen_mem (
  input  logic                      clk,
  input  tcw_pkg::mem_req_t         req,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] cells [CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      cells[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= cells[req.raddr];
    end
  end

endmodule

// ----- rtl/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// Console command sequencer
// Decodes commands, keeps the cursor and drives the sweep counter that
// copies rows upward and fills cells with spaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"

module tcw_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tcw_pkg::KIND_W-1:0]   in_kind,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tcw_pkg::FIELD_W-1:0]  in_column,
  input  logic [tcw_pkg::FIELD_W-1:0]  in_row_number,
  input  logic [tcw_pkg::FIELD_W-1:0]  in_line_count,
  input  logic [tcw_pkg::COLOR_W-1:0]  fg_color,
  output tcw_pkg::mem_req_t            mem_req,
  input  logic [tcw_pkg::CELL_W-1:0]   mem_rdata,
  output tcw_pkg::res_t                res,
  input  logic                         res_ready
);
  import tcw_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_COPY   = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_PUTC   = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  cursor_r, cursor_nxt;
  logic [ADDR_W-1:0]  row_start_r, row_start_nxt;
  logic [ADDR_W-1:0]  walk_r, walk_nxt;
  logic [ADDR_W-1:0]  dst_r, dst_nxt;
  logic [ADDR_W-1:0]  off_r, off_nxt;
  logic [ADDR_W-1:0]  keep_r, keep_nxt;
  logic               copy_pend_r, copy_pend_nxt;
  logic [CELL_W-1:0]  data_r, data_nxt;

  // latched command
  logic [KIND_W-1:0]  kind_r;
  logic [CHAR_W-1:0]  char_r;
  logic [FIELD_W-1:0] lines_r;
  logic [ADDR_W-1:0]  cell_addr_r;
  logic               in_range_r;

  logic [SCROLL_W-1:0] scroll_n;
  logic [ADDR_W-1:0]   scroll_off;
  logic [ADDR_W-1:0]   col_pos;
  logic [ADDR_W-1:0]   walk_inc;
  logic [CELL_W-1:0]   char_cell;
  logic [CELL_W-1:0]   space_cell;
  logic                accept;

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign char_cell  = {{(CELL_W - COLOR_W - CHAR_W){1'b0}}, fg_color, char_r};
  assign space_cell = {{(CELL_W - COLOR_W - CHAR_W){1'b0}}, fg_color, SPACE_CODE};
  assign col_pos    = cursor_r - row_start_r;
  assign walk_inc   = walk_r + ADDR_W'(1);

  // scroll distance: clamped line count for scroll, one row otherwise
  always_comb begin
    if (kind_r != KIND_SCROLL) begin
      scroll_n = SCROLL_W'(1);
    end else if (lines_r > FIELD_W'(ROWS)) begin
      scroll_n = SCROLL_W'(ROWS);
    end else begin
      scroll_n = lines_r[SCROLL_W-1:0];
    end
  end
  assign scroll_off = ADDR_W'(scroll_n * COLUMNS);

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r      <= in_kind;
      char_r      <= in_char_code;
      lines_r     <= in_line_count;
      cell_addr_r <= ADDR_W'(in_row_number * COLUMNS + in_column);
      in_range_r  <= (in_column < FIELD_W'(COLUMNS)) && (in_row_number < FIELD_W'(ROWS));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    row_start_nxt = row_start_r;
    walk_nxt      = walk_r;
    dst_nxt       = dst_r;
    off_nxt       = off_r;
    keep_nxt      = keep_r;
    copy_pend_nxt = 1'b0;
    data_nxt      = data_r;
    mem_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        data_nxt  = '0;
        state_nxt = S_DONE;
        walk_nxt  = '0;
        off_nxt   = scroll_off;
        keep_nxt  = ADDR_W'(CELLS) - scroll_off;
        unique case (kind_r)
          KIND_PUT_CHAR: begin
            if (cursor_r >= ADDR_W'(CELLS)) begin
              state_nxt = S_COPY;
            end else begin
              state_nxt = S_PUTC;
            end
          end
          KIND_NEW_LINE: begin
            if (cursor_r >= ADDR_W'(LAST_ROW_START)) begin
              state_nxt = S_COPY;
            end else begin
              cursor_nxt    = row_start_r + ADDR_W'(COLUMNS);
              row_start_nxt = row_start_r + ADDR_W'(COLUMNS);
            end
          end
          KIND_CR: begin
            cursor_nxt = row_start_r;
          end
          KIND_CLEAR: begin
            state_nxt = S_FILL;
          end
          KIND_PUT_AT: begin
            mem_req.we    = in_range_r;
            mem_req.waddr = cell_addr_r;
            mem_req.wdata = char_cell;
          end
          KIND_SCROLL: begin
            if (scroll_n != '0) begin
              state_nxt = S_COPY;
            end
          end
          KIND_READ: begin
            mem_req.re    = in_range_r;
            mem_req.raddr = cell_addr_r;
            if (in_range_r) begin
              state_nxt = S_READ;
            end
          end
          default: begin
          end
        endcase
      end

      // read the cell one scroll distance below, write it in the next cycle at its new place
      S_COPY: begin
        mem_req.we    = copy_pend_r;
        mem_req.waddr = dst_r;
        mem_req.wdata = mem_rdata;
        if (walk_r < keep_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = walk_r + off_r;
          dst_nxt       = walk_r;
          walk_nxt      = walk_inc;
          copy_pend_nxt = 1'b1;
        end else begin
          state_nxt = S_FILL;
        end
      end

      S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = walk_r;
        mem_req.wdata = space_cell;
        walk_nxt      = walk_inc;
        if (walk_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = S_DONE;
          unique case (kind_r)
            KIND_PUT_CHAR: begin
              cursor_nxt    = ADDR_W'(LAST_ROW_START);
              row_start_nxt = ADDR_W'(LAST_ROW_START);
              state_nxt     = S_PUTC;
            end
            KIND_NEW_LINE: begin
              cursor_nxt    = ADDR_W'(LAST_ROW_START);
              row_start_nxt = ADDR_W'(LAST_ROW_START);
            end
            KIND_CLEAR: begin
              cursor_nxt    = '0;
              row_start_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_PUTC: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cursor_r;
        mem_req.wdata = char_cell;
        cursor_nxt    = cursor_r + ADDR_W'(1);
        if (col_pos == ADDR_W'(COLUMNS - 1)) begin
          row_start_nxt = row_start_r + ADDR_W'(COLUMNS);
        end
        state_nxt = S_DONE;
      end

      S_READ: begin
        data_nxt  = mem_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      row_start_r <= '0;
      copy_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      row_start_r <= row_start_nxt;
      copy_pend_r <= copy_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r <= walk_nxt;
    dst_r  <= dst_nxt;
    off_r  <= off_nxt;
    keep_r <= keep_nxt;
    data_r <= data_nxt;
  end

  assign res.valid  = (state_r == S_DONE);
  assign res.cursor = cursor_r;
  assign res.data   = data_r;

  `TCW_ASSERT(a_cursor_bound, cursor_r <= ADDR_W'(CELLS))
  `TCW_ASSERT(a_row_start, (row_start_r <= cursor_r) && (col_pos < ADDR_W'(COLUMNS)))
  `TCW_ASSERT_IMPL(a_write_in_screen, mem_req.we, mem_req.waddr < ADDR_W'(CELLS))
  `TCW_ASSERT_IMPL(a_copy_pend_state, copy_pend_r, state_r == S_COPY)
  `TCW_ASSERT_IMPL(a_read_in_screen, mem_req.re, mem_req.raddr < ADDR_W'(CELLS))

endmodule

// ----- rtl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// Text console writer
// 80x25 text screen with linear cursor, color register and one result per
// command item.
// ----------------------------------------------------------------------------
// One command item is processed at a time. New line, carriage return, put at,
// an out-of-range read, the unused kind and a scroll of zero lines go from the
// decode state straight to done; put char and an in-range read pass the put or
// read state first. Clear, scroll and a new line or put char that has to scroll
// walk the screen memory (one write and one read port) under a sweep counter,
// one cell per cycle: space fill of all cells for clear; copy of the kept rows,
// a final step to write back the last copied cell, then space fill of the
// vacated rows for a scroll or a scrolling new line, followed by the put state
// for a scrolling put char. in_ready stays low while a command is in work and
// rises with the edge that registers the result, so the next item can be taken
// at the next edge. While the output register is full and not taken, the
// finished result waits in the sequencer and in_ready stays low.
// The screen is not cleared at reset: issue a clear first.
`timescale 1ns / 1ps

module text_console_writer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [tcw_pkg::COLOR_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tcw_pkg::KIND_W-1:0]   in_kind,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tcw_pkg::FIELD_W-1:0]  in_column,
  input  logic [tcw_pkg::FIELD_W-1:0]  in_row_number,
  input  logic [tcw_pkg::FIELD_W-1:0]  in_line_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tcw_pkg::ADDR_W-1:0]   out_cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]   out_cell_data
);
  import tcw_pkg::*;

  logic [COLOR_W-1:0] fg_color_r;
  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_cursor_r;
  logic [CELL_W-1:0]  out_data_r;
  mem_req_t           mem_req;
  logic [CELL_W-1:0]  mem_rdata;
  res_t               res;
  logic               res_ready;

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r  <= FG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fg_color_r <= cfg_wr_data;
      end
      if (res.valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_cursor_r <= res.cursor;
      out_data_r   <= res.data;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_cursor_r;
  assign out_cell_data       = out_data_r;

  tcw_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_char_code  (in_char_code),
    .in_column     (in_column),
    .in_row_number (in_row_number),
    .in_line_count (in_line_count),
    .fg_color      (fg_color_r),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata),
    .res           (res),
    .res_ready     (res_ready)
  );

  tcw_screen_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

// ----- bench/tb_text_console_writer.sv -----
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put char, cursor moves, clear, put at, scroll, read cell and unused-kind items
// through the valid/ready ports against a cycle-free screen model, checks
// every result item field by field, and changes the foreground color
// between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_console_writer;

  import tcw_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  localparam int DIRECTED_ITEMS = 24;
  localparam int PHASE_ITEMS    = 282;
  localparam int MAX_GAP        = 12;
  localparam int MAX_STALL      = 40;
  localparam int LONG_HOLD      = 400;
  localparam int SWEEP_CYCLES   = 2100;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  char_code;
    logic [FIELD_W-1:0] column;
    logic [FIELD_W-1:0] row_number;
    logic [FIELD_W-1:0] line_count;
  } console_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_position;
    logic [CELL_W-1:0] cell_data;
  } console_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [COLOR_W-1:0]  cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind = '0;
  logic [CHAR_W-1:0]   in_char_code = '0;
  logic [FIELD_W-1:0]  in_column = '0;
  logic [FIELD_W-1:0]  in_row_number = '0;
  logic [FIELD_W-1:0]  in_line_count = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ADDR_W-1:0]   out_cursor_position;
  logic [CELL_W-1:0]   out_cell_data;

  text_console_writer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_char_code        (in_char_code),
    .in_column           (in_column),
    .in_row_number       (in_row_number),
    .in_line_count       (in_line_count),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cursor_position (out_cursor_position),
    .out_cell_data       (out_cell_data)
  );

  always #5 clk = ~clk;

  // Screen model
  logic [CELL_W-1:0]  screen_model [CELLS];
  int                 cursor_model = 0;
  logic [COLOR_W-1:0] color_model = FG_RESET;
  int                 forced_scrolls = 0;

  console_cmd_t    pending_cmds [$];
  console_result_t expected_results [$];

  int     queued_items = 0;
  longint cycle_limit = 50000;
  longint cycles = 0;
  int     mismatches = 0;
  int     results_seen = 0;
  int     kind_seen [8];

  function automatic logic [CELL_W-1:0] colored_cell(input logic [CHAR_W-1:0] ch);
    return {{(CELL_W - COLOR_W - CHAR_W){1'b0}}, color_model, ch};
  endfunction

  task automatic scroll_screen(input int requested);
    int rows_up;
    int keep;
    rows_up = (requested > ROWS) ? ROWS : requested;
    keep = (ROWS - rows_up) * COLUMNS;
    for (int i = 0; i < keep; i++) screen_model[i] = screen_model[i + rows_up * COLUMNS];
    for (int i = keep; i < CELLS; i++) screen_model[i] = colored_cell(SPACE_CODE);
  endtask

  task automatic console_apply(input console_cmd_t c, output console_result_t r);
    bit hit;
    int addr;
    hit = (c.column < COLUMNS) && (c.row_number < ROWS);
    addr = int'(c.row_number) * COLUMNS + int'(c.column);
    r.cell_data = '0;
    case (c.kind)
      KIND_PUT_CHAR: begin
        if (cursor_model >= CELLS) begin
          scroll_screen(1);
          cursor_model = LAST_ROW_START;
          forced_scrolls++;
        end
        screen_model[cursor_model] = colored_cell(c.char_code);
        cursor_model++;
      end
      KIND_NEW_LINE: begin
        if (cursor_model >= LAST_ROW_START) begin
          scroll_screen(1);
          cursor_model = LAST_ROW_START;
          forced_scrolls++;
        end else begin
          cursor_model = (cursor_model / COLUMNS + 1) * COLUMNS;
        end
      end
      KIND_CR: cursor_model = (cursor_model / COLUMNS) * COLUMNS;
      KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = colored_cell(SPACE_CODE);
        cursor_model = 0;
      end
      KIND_PUT_AT: if (hit) screen_model[addr] = colored_cell(c.char_code);
      KIND_SCROLL: scroll_screen(c.line_count);
      KIND_READ: if (hit) r.cell_data = screen_model[addr];
      default: ;
    endcase
    r.cursor_position = ADDR_W'(cursor_model);
  endtask

  // Stimulus helpers
  task automatic push_cmd(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                          input logic [FIELD_W-1:0] col, input logic [FIELD_W-1:0] row,
                          input logic [FIELD_W-1:0] lines);
    console_cmd_t c;
    bit heavy;
    c = '{kind: kind, char_code: ch, column: col, row_number: row, line_count: lines};
    pending_cmds.push_back(c);
    queued_items++;
    // anything that may sweep the screen gets a full sweep in the budget
    heavy = (kind == KIND_PUT_CHAR) || (kind == KIND_NEW_LINE) || (kind == KIND_CLEAR) ||
            (kind == KIND_SCROLL);
    cycle_limit += 3 * ((heavy ? SWEEP_CYCLES : 10) + MAX_GAP + MAX_STALL);
  endtask

  function automatic logic [FIELD_W-1:0] pick_column();
    return ($urandom_range(0, 9) < 8) ? FIELD_W'($urandom_range(0, COLUMNS - 1))
                                      : FIELD_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [FIELD_W-1:0] pick_row();
    return ($urandom_range(0, 9) < 8) ? FIELD_W'($urandom_range(0, ROWS - 1))
                                      : FIELD_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [FIELD_W-1:0] any_byte();
    return FIELD_W'($urandom_range(0, 255));
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic gen_phase(input int goal, input bit run_off_first);
    int pick;
    int n;
    logic [FIELD_W-1:0] col;
    logic [FIELD_W-1:0] row;
    while (queued_items < goal) begin
      pick = run_off_first ? 0 : $urandom_range(0, 99);
      run_off_first = 1'b0;
      if (pick < 1) begin
        // walk the cursor to the last row, fill it, then run past the end
        push_cmd(KIND_CLEAR, any_byte(), any_byte(), any_byte(), any_byte());
        repeat (ROWS - 1) push_cmd(KIND_NEW_LINE, any_byte(), any_byte(), any_byte(), any_byte());
        n = COLUMNS + $urandom_range(1, 3);
        repeat (n) push_cmd(KIND_PUT_CHAR, any_byte(), any_byte(), any_byte(), any_byte());
        push_cmd(KIND_READ, any_byte(), 8'd0, FIELD_W'(ROWS - 1), any_byte());
        push_cmd(KIND_NEW_LINE, any_byte(), any_byte(), any_byte(), any_byte());
        push_cmd(KIND_READ, any_byte(), FIELD_W'($urandom_range(0, 3)), FIELD_W'(ROWS - 2),
                 any_byte());
      end else if (pick < 45) begin
        push_cmd(KIND_W'($urandom_range(0, 7)), any_byte(), pick_column(), pick_row(),
                 ($urandom_range(0, 4) < 3) ? FIELD_W'($urandom_range(0, ROWS + 1)) : any_byte());
      end else if (pick < 72) begin
        n = $urandom_range(1, 30);
        repeat (n) push_cmd(KIND_PUT_CHAR, any_byte(), any_byte(), any_byte(), any_byte());
      end else if (pick < 86) begin
        col = FIELD_W'($urandom_range(0, COLUMNS - 1));
        row = FIELD_W'($urandom_range(0, ROWS - 1));
        push_cmd(KIND_PUT_AT, any_byte(), col, row, any_byte());
        push_cmd(KIND_READ, any_byte(), col, row, any_byte());
      end else if (pick < 94) begin
        n = $urandom_range(1, 5);
        repeat (n) push_cmd(KIND_NEW_LINE, any_byte(), any_byte(), any_byte(), any_byte());
        push_cmd(KIND_PUT_CHAR, any_byte(), any_byte(), any_byte(), any_byte());
        if ($urandom_range(0, 1)) push_cmd(KIND_CR, any_byte(), any_byte(), any_byte(), any_byte());
      end else begin
        // out-of-range addresses and the unused kind
        col = FIELD_W'($urandom_range(COLUMNS, 255));
        row = FIELD_W'($urandom_range(ROWS, 255));
        case ($urandom_range(0, 2))
          0: push_cmd(KIND_PUT_AT, any_byte(), col, pick_row(), any_byte());
          1: push_cmd(KIND_READ, any_byte(), pick_column(), row, any_byte());
          default: push_cmd(KIND_UNUSED, any_byte(), any_byte(), any_byte(), any_byte());
        endcase
      end
    end
  endtask

  // Driver: bursts of items separated by random gaps
  console_cmd_t drv_cmd;
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        drv_cmd = pending_cmds.pop_front();
        in_kind       <= drv_cmd.kind;
        in_char_code  <= drv_cmd.char_code;
        in_column     <= drv_cmd.column;
        in_row_number <= drv_cmd.row_number;
        in_line_count <= drv_cmd.line_count;
        in_valid      <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, MAX_GAP);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern in segments, plus two long hold-offs
  int rx_count = 0;
  int hold_left = 0;
  int ready_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) rx_count++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready && (rx_count == 150 || rx_count == 750)) begin
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 3);
          mode_left = (ready_mode == 3) ? $urandom_range(1, 30) : $urandom_range(10, 200);
        end else begin
          mode_left--;
        end
        case (ready_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= 1'b0;
        endcase
      end
    end
  end

  // Monitor: check results first, then predict for the item taken at this edge
  console_cmd_t    seen_cmd;
  console_result_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result item with nothing outstanding: cursor_position %0d cell_data %h",
                 out_cursor_position, out_cell_data);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_cursor_position !== want.cursor_position) begin
            $error("cursor_position: expected %0d, got %0d", want.cursor_position,
                   out_cursor_position);
            mismatches++;
          end
          if (out_cell_data !== want.cell_data) begin
            $error("cell_data: expected %h, got %h", want.cell_data, out_cell_data);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        seen_cmd = '{kind: in_kind, char_code: in_char_code, column: in_column,
                     row_number: in_row_number, line_count: in_line_count};
        kind_seen[in_kind]++;
        console_apply(seen_cmd, want);
        expected_results.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > cycle_limit) begin
      $display("FAIL");
      $finish;
    end
  end

  logic [COLOR_W-1:0] phase_colors [4];

  initial begin
    foreach (kind_seen[k]) kind_seen[k] = 0;
    cycle_limit += 8 * LONG_HOLD;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: clear first so no read ever sees an unwritten cell
    push_cmd(KIND_CLEAR, any_byte(), any_byte(), any_byte(), any_byte());
    push_cmd(KIND_READ, any_byte(), 8'd0, 8'd0, any_byte());
    push_cmd(KIND_PUT_CHAR, 8'h00, any_byte(), any_byte(), any_byte());
    push_cmd(KIND_PUT_CHAR, 8'hff, any_byte(), any_byte(), any_byte());
    push_cmd(KIND_PUT_AT, 8'h41, FIELD_W'(COLUMNS - 1), FIELD_W'(ROWS - 1), any_byte());
    push_cmd(KIND_READ, any_byte(), FIELD_W'(COLUMNS - 1), FIELD_W'(ROWS - 1), any_byte());
    push_cmd(KIND_PUT_AT, 8'h42, FIELD_W'(COLUMNS), 8'd0, any_byte());
    push_cmd(KIND_PUT_AT, 8'h43, 8'd0, FIELD_W'(ROWS), any_byte());
    push_cmd(KIND_PUT_AT, 8'h44, 8'hff, 8'hff, any_byte());
    push_cmd(KIND_READ, any_byte(), FIELD_W'(COLUMNS), 8'd0, any_byte());
    push_cmd(KIND_READ, any_byte(), 8'd0, FIELD_W'(ROWS), any_byte());
    push_cmd(KIND_READ, any_byte(), 8'hff, 8'hff, any_byte());
    push_cmd(KIND_NEW_LINE, any_byte(), any_byte(), any_byte(), any_byte());
    push_cmd(KIND_PUT_CHAR, 8'h78, any_byte(), any_byte(), any_byte());
    push_cmd(KIND_CR, any_byte(), any_byte(), any_byte(), any_byte());
    push_cmd(KIND_SCROLL, any_byte(), any_byte(), any_byte(), 8'd0);
    push_cmd(KIND_SCROLL, any_byte(), any_byte(), any_byte(), 8'd1);
    push_cmd(KIND_READ, any_byte(), FIELD_W'(COLUMNS - 1), FIELD_W'(ROWS - 2), any_byte());
    push_cmd(KIND_READ, any_byte(), 8'd0, 8'd0, any_byte());
    push_cmd(KIND_SCROLL, any_byte(), any_byte(), any_byte(), FIELD_W'(ROWS));
    push_cmd(KIND_SCROLL, any_byte(), any_byte(), any_byte(), FIELD_W'(ROWS + 1));
    push_cmd(KIND_SCROLL, any_byte(), any_byte(), any_byte(), 8'hff);
    push_cmd(KIND_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff);
    push_cmd(KIND_READ, any_byte(), 8'd1, 8'd0, any_byte());
    wait_idle();

    phase_colors[0] = '0;
    phase_colors[1] = '1;
    phase_colors[2] = COLOR_W'($urandom_range(1, 14));
    phase_colors[3] = COLOR_W'($urandom_range(0, 15));
    for (int p = 0; p < 4; p++) begin
      @(posedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= phase_colors[p];
      color_model = phase_colors[p];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      @(negedge clk);
      gen_phase(DIRECTED_ITEMS + (p + 1) * PHASE_ITEMS, p == 0);
      wait_idle();
    end

    // leave room for a stray result from a late screen sweep
    repeat (SWEEP_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d items in %0d cycles; %0d scrolls forced by the cursor",
             results_seen, queued_items, cycles, forced_scrolls);
    $display("Items by kind: put %0d, newline %0d, cr %0d, clear %0d, put at %0d, scroll %0d, read %0d, unused %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
